[rtl/arm_pkg.sv]
// shared types and constants of the autoranging resistance meter
`timescale 1ns / 1ps

package arm_pkg;

  // default configuration of the design
  localparam int NUM_RANGES_DEF = 4;
  localparam int ADC_BITS_DEF   = 10;

  // fixed field widths
  localparam int THR_W   = 10;
  localparam int REF_W   = 12;
  localparam int RNG_W   = 3;
  localparam int RES_W   = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 12;

  // register reset values
  localparam logic [THR_W-1:0] THR_RESET = 10'd700;
  localparam logic [REF_W-1:0] REF_RESET = 12'd560;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REF_RES   = 2'd1;

  // request kinds
  localparam logic REQ_START  = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  // range codes
  localparam logic [RNG_W-1:0] RANGE_IDLE   = 3'd0;
  localparam logic [RNG_W-1:0] RANGE_FIRST  = 3'd1;
  localparam logic [RNG_W-1:0] RANGE_STRICT = 3'd4;

  localparam logic [RES_W-1:0] RES_MAX = 32'hFFFF_FFFF;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_SCALE,
    ST_EMIT
  } state_t;

  // status of a serial arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

[rtl/arm_mul.sv]
// bit-serial shift-add multiplier, sample times reference resistance
`timescale 1ns / 1ps

module arm_mul #(
  parameter int ADC_BITS = arm_pkg::ADC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [ADC_BITS-1:0]               sample,
  input  logic [arm_pkg::REF_W-1:0]         ref_val,
  output logic [ADC_BITS+arm_pkg::REF_W-1:0] product,
  output arm_pkg::unit_stat_t               stat
);

  localparam int RW = arm_pkg::REF_W;
  localparam int CW = $clog2(ADC_BITS + 1);

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [RW-1:0]       hi_r, hi_nxt;
  logic [ADC_BITS-1:0] lo_r, lo_nxt;
  logic [RW:0]         sum;

  // one multiplier bit per cycle, lsb first
  assign sum = {1'b0, hi_r} + (lo_r[0] ? {1'b0, ref_val} : {(RW+1){1'b0}});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    hi_nxt   = hi_r;
    lo_nxt   = lo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(ADC_BITS);
      hi_nxt   = '0;
      lo_nxt   = sample;
    end else if (busy_r) begin
      hi_nxt  = sum[RW:1];
      lo_nxt  = {sum[0], lo_r[ADC_BITS-1:1]};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    hi_r <= hi_nxt;
    lo_r <= lo_nxt;
  end

  assign product   = {hi_r, lo_r};
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

[rtl/arm_div.sv]
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module arm_div #(
  parameter int NUM_W = arm_pkg::ADC_BITS_DEF + arm_pkg::REF_W,
  parameter int DEN_W = arm_pkg::ADC_BITS_DEF + 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [NUM_W-1:0]     dividend,
  input  logic [DEN_W-1:0]     divisor,
  output logic [NUM_W-1:0]     quotient,
  output arm_pkg::unit_stat_t  stat
);

  localparam int CW = $clog2(NUM_W + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [NUM_W-1:0] n_r, n_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             fits;

  assign trial = {rem_r, n_r[NUM_W-1]};
  assign fits  = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    n_nxt    = n_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(NUM_W);
      n_nxt    = dividend;
      rem_nxt  = '0;
      den_nxt  = divisor;
    end else if (busy_r) begin
      // remainder stays below the divisor, so it fits back in DEN_W bits
      rem_nxt = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      n_nxt   = {n_r[NUM_W-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    n_r   <= n_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign quotient  = n_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

[rtl/autorange_resistance_meter.sv]
// top level of the autoranging resistance meter sequencer
`timescale 1ns / 1ps

// channel  direction  word
// in_      slave      tuser = req_type, tdata[9:0] = adc_sample
// out_     master     tdata = drive_range, range_used, resistance; tlast = done_res;
//                     tuser = status
// cfg_     slave      cfg_index selects threshold or ref_resistance, cfg_data = value
//
// a start word, a sample while idle and an out-of-range sample go from idle straight to emit
// an in-range sample passes through the mul, div, scale and emit states: the bit-serial
// multiplier, the restoring divider and a times-ten step for each range above the first
// one word is worked on at a time; in_tready is high only while the sequencer is idle
// a finished word waits in the output register while the next input word is taken
// synchronous active-low reset clears the range, the registers to their defaults
// and the output valid

module autorange_resistance_meter #(
  parameter int NUM_RANGES = arm_pkg::NUM_RANGES_DEF,
  parameter int ADC_BITS   = arm_pkg::ADC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [9:0] adc_sample, [15:10] zero
  input  logic        in_tuser,   // [0] req_type
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [2:0] drive_range, [5:3] range_used,
                                  // [37:6] resistance, [39:38] zero
  output logic        out_tlast,  // done_res
  output logic        out_tuser,  // [0] status
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [arm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [arm_pkg::CFG_DAT_W-1:0] cfg_data
);

  localparam int RW    = arm_pkg::REF_W;
  localparam int TW    = arm_pkg::THR_W;
  localparam int NW    = ADC_BITS + RW;     // product and quotient width
  localparam int DW    = ADC_BITS + 1;      // divisor width
  localparam int CMP_W = ADC_BITS + TW;
  localparam int GW    = arm_pkg::RNG_W;

  arm_pkg::state_t state_r, state_nxt;

  // configuration registers
  logic [TW-1:0] thr_r;
  logic [RW-1:0] ref_r;

  // range being measured, zero while idle
  logic [GW-1:0] range_r, range_nxt;

  // pending result word
  logic [GW-1:0]             pend_drive_r, pend_drive_nxt;
  logic                      pend_done_r, pend_done_nxt;
  logic                      pend_stat_r, pend_stat_nxt;
  logic [GW-1:0]             pend_rng_r, pend_rng_nxt;
  logic [arm_pkg::RES_W-1:0] val_r, val_nxt;
  logic [GW-1:0]             scl_cnt_r, scl_cnt_nxt;
  logic [ADC_BITS-1:0]       samp_r, samp_nxt;

  // output register
  logic                      out_valid_r;
  logic [GW-1:0]             out_drive_r;
  logic                      out_done_r;
  logic                      out_stat_r;
  logic [GW-1:0]             out_rng_r;
  logic [arm_pkg::RES_W-1:0] out_res_r;

  // item decode
  logic                  accept;
  logic [ADC_BITS+9:0]   samp_ext;
  logic [ADC_BITS-1:0]   samp;
  logic [CMP_W-1:0]      samp_cmp;
  logic [CMP_W-1:0]      thr_cmp;
  logic                  in_range;
  logic                  go_compute;
  logic                  emit_load;

  // arithmetic units
  logic                mul_start;
  logic                div_start;
  logic [NW-1:0]       product;
  logic [NW-1:0]       quotient;
  logic [DW-1:0]       divisor;
  arm_pkg::unit_stat_t mul_stat;
  arm_pkg::unit_stat_t div_stat;

  // times-ten step with saturation
  logic [arm_pkg::RES_W+3:0] val_x10;
  logic [arm_pkg::RES_W-1:0] val_scaled;

  assign accept = in_tvalid && in_tready;

  // mask the sample to the adc width
  assign samp_ext = {{ADC_BITS{1'b0}}, in_tdata[9:0]};
  assign samp     = samp_ext[ADC_BITS-1:0];
  assign samp_cmp = {{TW{1'b0}}, samp};
  assign thr_cmp  = {{ADC_BITS{1'b0}}, thr_r};

  // range 4, the top range at the default of four ranges, must be strictly below the threshold
  assign in_range = (range_r == arm_pkg::RANGE_STRICT) ? (samp_cmp < thr_cmp)
                                                       : (samp_cmp <= thr_cmp);

  assign go_compute = accept && (in_tuser == arm_pkg::REQ_SAMPLE) &&
                      (range_r != arm_pkg::RANGE_IDLE) && in_range;

  assign emit_load = (state_r == arm_pkg::ST_EMIT) && (!out_valid_r || out_tready);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      arm_pkg::ST_IDLE: begin
        if (go_compute) begin
          state_nxt = arm_pkg::ST_MUL;
        end else if (accept) begin
          state_nxt = arm_pkg::ST_EMIT;
        end
      end
      arm_pkg::ST_MUL: begin
        if (mul_stat.done) begin
          state_nxt = arm_pkg::ST_DIV;
        end
      end
      arm_pkg::ST_DIV: begin
        if (div_stat.done) begin
          state_nxt = arm_pkg::ST_SCALE;
        end
      end
      arm_pkg::ST_SCALE: begin
        if (scl_cnt_r == '0) begin
          state_nxt = arm_pkg::ST_EMIT;
        end
      end
      arm_pkg::ST_EMIT: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = arm_pkg::ST_IDLE;
        end
      end
      default: state_nxt = arm_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_tready = 1'b0;
    mul_start = 1'b0;
    div_start = 1'b0;
    unique case (state_r)
      arm_pkg::ST_IDLE:  begin
        in_tready = 1'b1;
        mul_start = go_compute;
      end
      arm_pkg::ST_MUL:   div_start = mul_stat.done;
      arm_pkg::ST_DIV:   ;
      arm_pkg::ST_SCALE: ;
      arm_pkg::ST_EMIT:  ;
      default:           ;
    endcase
  end

  assign cfg_ready = 1'b1;

  // saturating multiply by ten: 8x + 2x
  assign val_x10    = {val_r, 3'b000} + {2'b00, val_r, 1'b0};
  assign val_scaled = (val_x10[arm_pkg::RES_W+3:arm_pkg::RES_W] != 4'd0) ?
                      arm_pkg::RES_MAX : val_x10[arm_pkg::RES_W-1:0];

  // divisor is full scale minus the sample, never zero
  assign divisor = {1'b1, {ADC_BITS{1'b0}}} - {1'b0, samp_r};

  // datapath of the sequencer
  always_comb begin
    range_nxt      = range_r;
    pend_drive_nxt = pend_drive_r;
    pend_done_nxt  = pend_done_r;
    pend_stat_nxt  = pend_stat_r;
    pend_rng_nxt   = pend_rng_r;
    val_nxt        = val_r;
    scl_cnt_nxt    = scl_cnt_r;
    samp_nxt       = samp_r;
    if (accept) begin
      pend_drive_nxt = arm_pkg::RANGE_IDLE;
      pend_done_nxt  = 1'b0;
      pend_stat_nxt  = 1'b0;
      pend_rng_nxt   = arm_pkg::RANGE_IDLE;
      val_nxt        = '0;
      samp_nxt       = samp;
      if (in_tuser == arm_pkg::REQ_START) begin
        // start or restart at the first range
        range_nxt      = arm_pkg::RANGE_FIRST;
        pend_drive_nxt = arm_pkg::RANGE_FIRST;
      end else if (range_r != arm_pkg::RANGE_IDLE) begin
        if (in_range) begin
          pend_done_nxt = 1'b1;
          pend_rng_nxt  = range_r;
          scl_cnt_nxt   = range_r - 1'b1;
          range_nxt     = arm_pkg::RANGE_IDLE;
        end else if (range_r < GW'(NUM_RANGES)) begin
          range_nxt      = range_r + 1'b1;
          pend_drive_nxt = range_r + 1'b1;
        end else begin
          // overrange on every range
          pend_done_nxt = 1'b1;
          pend_stat_nxt = 1'b1;
          range_nxt     = arm_pkg::RANGE_IDLE;
        end
      end
    end else if (state_r == arm_pkg::ST_DIV && div_stat.done) begin
      val_nxt = arm_pkg::RES_W'(quotient);
    end else if (state_r == arm_pkg::ST_SCALE && scl_cnt_r != '0) begin
      val_nxt     = val_scaled;
      scl_cnt_nxt = scl_cnt_r - 1'b1;
    end
  end

  // configuration, state and output registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= arm_pkg::ST_IDLE;
      range_r     <= arm_pkg::RANGE_IDLE;
      thr_r       <= arm_pkg::THR_RESET;
      ref_r       <= arm_pkg::REF_RESET;
      out_valid_r <= 1'b0;
      scl_cnt_r   <= '0;
    end else begin
      state_r   <= state_nxt;
      range_r   <= range_nxt;
      scl_cnt_r <= scl_cnt_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          arm_pkg::CFG_THRESHOLD: thr_r <= cfg_data[TW-1:0];
          arm_pkg::CFG_REF_RES:   ref_r <= cfg_data[RW-1:0];
          default:                ;
        endcase
      end
      if (emit_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
    pend_drive_r <= pend_drive_nxt;
    pend_done_r  <= pend_done_nxt;
    pend_stat_r  <= pend_stat_nxt;
    pend_rng_r   <= pend_rng_nxt;
    val_r        <= val_nxt;
    samp_r       <= samp_nxt;
    if (emit_load) begin
      out_drive_r <= pend_drive_r;
      out_done_r  <= pend_done_r;
      out_stat_r  <= pend_stat_r;
      out_rng_r   <= pend_rng_r;
      out_res_r   <= val_r;
    end
  end

  arm_mul #(
    .ADC_BITS (ADC_BITS)
  ) u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .sample  (samp),
    .ref_val (ref_r),
    .product (product),
    .stat    (mul_stat)
  );

  arm_div #(
    .NUM_W (NW),
    .DEN_W (DW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (product),
    .divisor  (divisor),
    .quotient (quotient),
    .stat     (div_stat)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_res_r, out_rng_r, out_drive_r};
  assign out_tlast  = out_done_r;
  assign out_tuser  = out_stat_r;

endmodule

[rtl/arm_chk.sv]
// port checker of the autoranging resistance meter and its bind
`timescale 1ns / 1ps

module arm_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic        out_tlast,
  input logic        out_tuser
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
                                  $stable(out_tlast) && $stable(out_tuser))
    else $error("stalled result word changed");

  // one word in flight: no input taken right after one was taken
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken on two cycles in a row");

  // unfinished steps carry no status, range used or resistance
  a_not_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !out_tuser && out_tdata[37:3] == 35'd0)
    else $error("result fields set before measurement finished");

  // overrange reports no range and no value
  a_overrange: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[37:0] == 38'd0)
    else $error("overrange word carries range or value");

  // reset empties the output register
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind autorange_resistance_meter arm_chk u_arm_chk (.*);
